// ===== rtl/dvl_pkg.sv =====
// ----------------------------------------------------------------------------
// dvl_pkg
// Shared types, codes and constants of the differential-drive velocity
// limiter: register map, datapath commands and status, default parameters.
// ----------------------------------------------------------------------------
package dvl_pkg;

    // Default values of the top-level parameters.
    localparam int VEL_FRAC_BITS_DEF       = 12;
    localparam int PHASE1_END_TICKS_DEF    = 1000;
    localparam int PHASE2_END_TICKS_DEF    = 2500;
    localparam int PHASE1_LINEAR_LIMIT_DEF = 410;
    localparam int BOOST_MAX_LINEAR_DEF    = 1229;
    localparam int BOOST_MAX_ANGULAR_DEF   = 819;

    // Width of the working magnitudes and of the shared arithmetic unit.
    localparam int ACC_W    = 64;
    localparam int TICK_W   = 12;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] REQ_CMD    = 2'd0;
    localparam logic [1:0] REQ_STATUS = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Status event codes.
    localparam logic [2:0] ST_DRIVING  = 3'd0;
    localparam logic [2:0] ST_RECOVERY = 3'd1;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_LIMIT_MODE    = 3'd0;
    localparam logic [2:0] REG_SPEED_SCALE   = 3'd1;
    localparam logic [2:0] REG_LIMIT_LINEAR  = 3'd2;
    localparam logic [2:0] REG_LIMIT_ANGULAR = 3'd3;
    localparam logic [2:0] REG_PHASE2_LIMIT  = 3'd4;
    localparam logic [2:0] REG_STARTUP_ANG   = 3'd5;
    localparam logic [2:0] REG_MIN_WHEEL     = 3'd6;
    localparam logic [2:0] REG_HALF_TRACK    = 3'd7;

    // Datapath operations.
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_STATUS  = 5'd2;
    localparam logic [4:0] OP_TICK    = 5'd3;
    localparam logic [4:0] OP_SET1    = 5'd4;
    localparam logic [4:0] OP_DIV_V   = 5'd5;
    localparam logic [4:0] OP_DIV_W   = 5'd6;
    localparam logic [4:0] OP_MUL_VSC = 5'd7;
    localparam logic [4:0] OP_MUL_WSC = 5'd8;
    localparam logic [4:0] OP_MUL_VSS = 5'd9;
    localparam logic [4:0] OP_MUL_WSS = 5'd10;
    localparam logic [4:0] OP_WHEEL   = 5'd11;
    localparam logic [4:0] OP_DIV_SB  = 5'd12;
    localparam logic [4:0] OP_COPY    = 5'd13;
    localparam logic [4:0] OP_MUL_VSB = 5'd14;
    localparam logic [4:0] OP_MUL_WSB = 5'd15;
    localparam logic [4:0] OP_MUL_KP  = 5'd16;
    localparam logic [4:0] OP_DECIDE  = 5'd17;
    localparam logic [4:0] OP_OUT     = 5'd18;

    // Which limit pair a limit pass uses; also the return point of the pass.
    localparam logic [1:0] LIM_START = 2'd0;
    localparam logic [1:0] LIM_MODE  = 2'd1;
    localparam logic [1:0] LIM_BOOST = 2'd2;

    typedef struct packed {
        logic [1:0]  limit_mode;
        logic [16:0] speed_scale;
        logic [14:0] limit_linear;
        logic [14:0] limit_angular;
        logic [14:0] phase2_limit;
        logic [14:0] startup_angular;
        logic [14:0] min_wheel_speed;
        logic [14:0] half_track;
    } cfg_t;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] lim;
    } dp_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic cond_v;
        logic cond_w;
        logic phase_nz;
        logic mode_nz;
        logic recovery;
        logic boost_ok;
    } dp_stat_t;

endpackage

// ===== rtl/diff_drive_velocity_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// diff_drive_velocity_limiter_unit
// Velocity limiter for a differential-drive base with startup, mode and
// recovery-boost stages, Q4.12 fixed point, APB configuration.
// ----------------------------------------------------------------------------
// Status events and ticks are executed as they are accepted; the next request is
// taken in the following cycle. A velocity command runs only the active stages
// (all stages: seven divisions); its duration is set mostly by the shared
// bit-serial divider, which loads and then runs each division in turn.
// Multiplications use a 16-bit digit per cycle. One request at a time.
// rst_n clears the timer, the status flags and the sequencer at once and
// loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
module diff_drive_velocity_limiter_unit #(
    parameter int VEL_FRAC_BITS       = dvl_pkg::VEL_FRAC_BITS_DEF,
    parameter int PHASE1_END_TICKS    = dvl_pkg::PHASE1_END_TICKS_DEF,
    parameter int PHASE2_END_TICKS    = dvl_pkg::PHASE2_END_TICKS_DEF,
    parameter int PHASE1_LINEAR_LIMIT = dvl_pkg::PHASE1_LINEAR_LIMIT_DEF,
    parameter int BOOST_MAX_LINEAR    = dvl_pkg::BOOST_MAX_LINEAR_DEF,
    parameter int BOOST_MAX_ANGULAR   = dvl_pkg::BOOST_MAX_ANGULAR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // v_in[15:0], w_in[31:16], status_code[34:32]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // v_out[15:0], w_out[31:16], startup_phase[33:32],
                                   // boosted[34]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dvl_pkg::cfg_t      cfg_reg;
    dvl_pkg::dp_cmd_t   cmd;
    dvl_pkg::dp_stat_t  stat;
    logic [2:0]         reg_idx;
    logic               cfg_wr;
    logic signed [15:0] v_out, w_out;
    logic [1:0]         startup_phase;
    logic               boosted;

    // The register index is the word address; writes complete in the access
    // cycle since the port never stalls.
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_mode      <= 2'd0;
            cfg_reg.speed_scale     <= dvl_pkg::ONE_Q16;
            cfg_reg.limit_linear    <= 15'd0;
            cfg_reg.limit_angular   <= 15'd0;
            cfg_reg.phase2_limit    <= 15'd1229;
            cfg_reg.startup_angular <= 15'd2048;
            cfg_reg.min_wheel_speed <= 15'd82;
            cfg_reg.half_track      <= 15'd1077;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                dvl_pkg::REG_LIMIT_MODE:
                    cfg_reg.limit_mode <= pwdata[1:0];
                dvl_pkg::REG_SPEED_SCALE:
                    // A scale above 1.0 is clamped to 1.0.
                    cfg_reg.speed_scale <= (pwdata[16:0] > dvl_pkg::ONE_Q16)
                                           ? dvl_pkg::ONE_Q16 : pwdata[16:0];
                dvl_pkg::REG_LIMIT_LINEAR:  cfg_reg.limit_linear    <= pwdata[14:0];
                dvl_pkg::REG_LIMIT_ANGULAR: cfg_reg.limit_angular   <= pwdata[14:0];
                dvl_pkg::REG_PHASE2_LIMIT:  cfg_reg.phase2_limit    <= pwdata[14:0];
                dvl_pkg::REG_STARTUP_ANG:   cfg_reg.startup_angular <= pwdata[14:0];
                dvl_pkg::REG_MIN_WHEEL:     cfg_reg.min_wheel_speed <= pwdata[14:0];
                dvl_pkg::REG_HALF_TRACK:    cfg_reg.half_track      <= pwdata[14:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dvl_pkg::REG_LIMIT_MODE:    prdata = 32'(cfg_reg.limit_mode);
            dvl_pkg::REG_SPEED_SCALE:   prdata = 32'(cfg_reg.speed_scale);
            dvl_pkg::REG_LIMIT_LINEAR:  prdata = 32'(cfg_reg.limit_linear);
            dvl_pkg::REG_LIMIT_ANGULAR: prdata = 32'(cfg_reg.limit_angular);
            dvl_pkg::REG_PHASE2_LIMIT:  prdata = 32'(cfg_reg.phase2_limit);
            dvl_pkg::REG_STARTUP_ANG:   prdata = 32'(cfg_reg.startup_angular);
            dvl_pkg::REG_MIN_WHEEL:     prdata = 32'(cfg_reg.min_wheel_speed);
            default:                    prdata = 32'(cfg_reg.half_track);
        endcase
    end

    // The sequencer decides the order of the passes; the datapath holds the
    // magnitudes, signs and scale factors and owns the shared arithmetic unit.
    dvl_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .req_type  (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dvl_datapath #(
        .VEL_FRAC_BITS       (VEL_FRAC_BITS),
        .PHASE1_END_TICKS    (PHASE1_END_TICKS),
        .PHASE2_END_TICKS    (PHASE2_END_TICKS),
        .PHASE1_LINEAR_LIMIT (PHASE1_LINEAR_LIMIT),
        .BOOST_MAX_LINEAR    (BOOST_MAX_LINEAR),
        .BOOST_MAX_ANGULAR   (BOOST_MAX_ANGULAR)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .v_in          (s_tdata[15:0]),
        .w_in          (s_tdata[31:16]),
        .status_code   (s_tdata[34:32]),
        .stat          (stat),
        .v_out         (v_out),
        .w_out         (w_out),
        .startup_phase (startup_phase),
        .boosted       (boosted)
    );

    // The result is held in the datapath's output registers until taken.
    assign m_tdata = {5'd0, boosted, startup_phase, w_out, v_out};

endmodule

// ===== rtl/dvl_datapath.sv =====
// ----------------------------------------------------------------------------
// dvl_datapath
// Working registers, status tracking and the shared serial multiply/divide
// unit of the velocity limiter. Executes one command from the controller.
// ----------------------------------------------------------------------------
module dvl_datapath #(
    parameter int VEL_FRAC_BITS       = dvl_pkg::VEL_FRAC_BITS_DEF,
    parameter int PHASE1_END_TICKS    = dvl_pkg::PHASE1_END_TICKS_DEF,
    parameter int PHASE2_END_TICKS    = dvl_pkg::PHASE2_END_TICKS_DEF,
    parameter int PHASE1_LINEAR_LIMIT = dvl_pkg::PHASE1_LINEAR_LIMIT_DEF,
    parameter int BOOST_MAX_LINEAR    = dvl_pkg::BOOST_MAX_LINEAR_DEF,
    parameter int BOOST_MAX_ANGULAR   = dvl_pkg::BOOST_MAX_ANGULAR_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dvl_pkg::cfg_t        cfg,
    input  dvl_pkg::dp_cmd_t     cmd,
    input  logic signed [15:0]   v_in,
    input  logic signed [15:0]   w_in,
    input  logic [2:0]           status_code,
    output dvl_pkg::dp_stat_t    stat,
    output logic signed [15:0]   v_out,
    output logic signed [15:0]   w_out,
    output logic [1:0]           startup_phase,
    output logic                 boosted
);

    localparam int W      = dvl_pkg::ACC_W;
    localparam int TICK_W = dvl_pkg::TICK_W;

    // Control state.
    logic                          driving_reg;
    logic                          last_drv_reg;
    logic                          recovery_reg;
    logic [dvl_pkg::TICK_W-1:0]    ticks_reg;
    logic                          u_busy_reg;
    logic                          u_div_reg;
    logic [5:0]                    u_cnt_reg;

    // Payload.
    logic [W-1:0]  vm_reg, wm_reg, tv_reg, tw_reg, sb_reg, mw_reg;
    logic [16:0]   sc_reg;
    logic          vs_reg, ws_reg, boost_reg;
    logic [W-1:0]  u_a_reg, u_b_reg, u_acc_reg;
    logic signed [15:0] v_out_reg, w_out_reg;
    logic [1:0]    phase_out_reg;
    logic          boosted_out_reg;

    logic [1:0]    phase;
    logic [14:0]   lim_v, lim_w;
    logic          is_mul, is_div;
    logic [W-1:0]  op_a, op_b;
    logic [W-1:0]  mul_next;
    logic [W:0]    rem_sh;
    logic          rem_ge;
    logic [W-1:0]  rem_next, quo_next, u_res;
    logic          u_done;
    logic [31:0]   wheel_w;
    logic [W-1:0]  wheel_next;
    logic [16:0]   v_abs, w_abs;

    // Startup phase from the driving timer.
    always_comb
    begin
        phase = 2'd0;
        if (driving_reg)
        begin
            if (ticks_reg < TICK_W'(PHASE1_END_TICKS))
                phase = 2'd1;
            else if (ticks_reg < TICK_W'(PHASE2_END_TICKS))
                phase = (cfg.phase2_limit != 15'd0) ? 2'd2 : 2'd0;
        end
    end

    always_comb
    begin
        unique case (cmd.lim)
            dvl_pkg::LIM_START:
            begin
                lim_v = (phase == 2'd1) ? 15'(PHASE1_LINEAR_LIMIT) : cfg.phase2_limit;
                lim_w = cfg.startup_angular;
            end
            dvl_pkg::LIM_MODE:
            begin
                lim_v = cfg.limit_linear;
                lim_w = cfg.limit_angular;
            end
            default:
            begin
                lim_v = 15'(BOOST_MAX_LINEAR);
                lim_w = 15'(BOOST_MAX_ANGULAR);
            end
        endcase
    end

    // Operand selection for the shared unit; the narrow factor goes to b.
    always_comb
    begin
        is_mul = 1'b0;
        is_div = 1'b0;
        op_a   = '0;
        op_b   = '0;
        unique case (cmd.op)
            dvl_pkg::OP_DIV_V:
            begin
                is_div = 1'b1;
                op_a   = W'(vm_reg);
                op_b   = W'(lim_v) << 16;
            end
            dvl_pkg::OP_DIV_W:
            begin
                is_div = 1'b1;
                op_a   = wm_reg;
                op_b   = W'(lim_w) << 16;
            end
            dvl_pkg::OP_DIV_SB:
            begin
                is_div = 1'b1;
                op_a   = mw_reg;
                op_b   = W'(cfg.min_wheel_speed) << (2 * VEL_FRAC_BITS + 16);
            end
            dvl_pkg::OP_MUL_VSC:
            begin
                is_mul = 1'b1;
                op_a   = vm_reg;
                op_b   = W'(sc_reg);
            end
            dvl_pkg::OP_MUL_WSC:
            begin
                is_mul = 1'b1;
                op_a   = wm_reg;
                op_b   = W'(sc_reg);
            end
            dvl_pkg::OP_MUL_VSS:
            begin
                is_mul = 1'b1;
                op_a   = vm_reg;
                op_b   = W'(cfg.speed_scale);
            end
            dvl_pkg::OP_MUL_WSS:
            begin
                is_mul = 1'b1;
                op_a   = wm_reg;
                op_b   = W'(cfg.speed_scale);
            end
            dvl_pkg::OP_MUL_VSB:
            begin
                is_mul = 1'b1;
                op_a   = sb_reg;
                op_b   = tv_reg;
            end
            dvl_pkg::OP_MUL_WSB:
            begin
                is_mul = 1'b1;
                op_a   = sb_reg;
                op_b   = tw_reg;
            end
            dvl_pkg::OP_MUL_KP:
            begin
                is_mul = 1'b1;
                op_a   = sb_reg;
                op_b   = W'(sc_reg);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    // One 16-bit digit of the multiplier, or one quotient bit, per cycle.
    assign mul_next = u_acc_reg + W'(u_a_reg * u_b_reg[15:0]);
    assign rem_sh   = {u_acc_reg, u_b_reg[W-1]};
    assign rem_ge   = rem_sh >= {1'b0, u_a_reg};
    assign rem_next = rem_ge ? W'(rem_sh - {1'b0, u_a_reg}) : rem_sh[W-1:0];
    assign quo_next = {u_b_reg[W-2:0], rem_ge};
    assign u_done   = u_busy_reg && (u_div_reg ? (u_cnt_reg == 6'd63)
                                               : (u_b_reg[W-1:16] == '0));
    assign u_res    = u_div_reg ? quo_next : mul_next;

    assign wheel_w    = 32'(wm_reg[16:0]) * 32'(cfg.half_track);
    assign wheel_next = (W'(vm_reg[16:0]) << VEL_FRAC_BITS) + W'(wheel_w);

    assign v_abs = v_in[15] ? 17'(17'd0 - 17'(v_in)) : 17'(v_in);
    assign w_abs = w_in[15] ? 17'(17'd0 - 17'(w_in)) : 17'(w_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            driving_reg  <= 1'b0;
            last_drv_reg <= 1'b0;
            recovery_reg <= 1'b0;
            ticks_reg    <= '0;
            u_busy_reg   <= 1'b0;
            u_div_reg    <= 1'b0;
            u_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.op == dvl_pkg::OP_STATUS)
            begin
                if (status_code == dvl_pkg::ST_DRIVING)
                begin
                    if (!last_drv_reg)
                    begin
                        driving_reg <= 1'b1;
                        ticks_reg   <= '0;
                    end
                end
                else
                begin
                    driving_reg <= 1'b0;
                    ticks_reg   <= '0;
                end
                last_drv_reg <= (status_code == dvl_pkg::ST_DRIVING);
                recovery_reg <= (status_code == dvl_pkg::ST_RECOVERY);
            end
            if (cmd.op == dvl_pkg::OP_TICK && driving_reg && ticks_reg != '1)
                ticks_reg <= ticks_reg + 1'b1;

            if (u_done)
                u_busy_reg <= 1'b0;
            else if (!u_busy_reg && (is_mul || is_div))
            begin
                u_busy_reg <= 1'b1;
                u_div_reg  <= is_div;
                u_cnt_reg  <= '0;
            end
            else if (u_busy_reg)
                u_cnt_reg <= u_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        // Shared unit payload.
        if (!u_busy_reg && (is_mul || is_div))
        begin
            u_a_reg   <= op_a;
            u_b_reg   <= op_b;
            u_acc_reg <= '0;
        end
        else if (u_busy_reg)
        begin
            if (u_div_reg)
            begin
                u_acc_reg <= rem_next;
                u_b_reg   <= quo_next;
            end
            else
            begin
                u_acc_reg <= mul_next;
                u_a_reg   <= u_a_reg << 16;
                u_b_reg   <= u_b_reg >> 16;
            end
        end

        unique case (cmd.op)
            dvl_pkg::OP_LOAD:
            begin
                vm_reg    <= W'(v_abs);
                wm_reg    <= W'(w_abs);
                vs_reg    <= v_in[15];
                ws_reg    <= w_in[15];
                boost_reg <= 1'b0;
            end
            dvl_pkg::OP_SET1:
                sc_reg <= dvl_pkg::ONE_Q16;
            dvl_pkg::OP_DIV_V, dvl_pkg::OP_DIV_W:
                if (u_done && u_res < W'(sc_reg))
                    sc_reg <= u_res[16:0];
            dvl_pkg::OP_DIV_SB:
                if (u_done)
                    sb_reg <= u_res;
            dvl_pkg::OP_MUL_VSC, dvl_pkg::OP_MUL_VSS, dvl_pkg::OP_MUL_VSB:
                if (u_done)
                    vm_reg <= u_res >> 16;
            dvl_pkg::OP_MUL_WSC, dvl_pkg::OP_MUL_WSS, dvl_pkg::OP_MUL_WSB:
                if (u_done)
                    wm_reg <= u_res >> 16;
            dvl_pkg::OP_MUL_KP:
                if (u_done)
                    mw_reg <= u_res;
            dvl_pkg::OP_WHEEL:
                mw_reg <= wheel_next;
            dvl_pkg::OP_COPY:
            begin
                tv_reg <= vm_reg;
                tw_reg <= wm_reg;
            end
            dvl_pkg::OP_DECIDE:
            begin
                // The clipped boost is kept only if it still raises the speed.
                if ((mw_reg >> 16) > W'(dvl_pkg::ONE_Q16))
                    boost_reg <= 1'b1;
                else
                begin
                    vm_reg <= tv_reg;
                    wm_reg <= tw_reg;
                end
            end
            dvl_pkg::OP_OUT:
            begin
                if (vs_reg)
                    v_out_reg <= (vm_reg > W'(32768)) ? 16'sh8000
                                 : 16'(17'd0 - vm_reg[16:0]);
                else
                    v_out_reg <= (vm_reg > W'(32767)) ? 16'sh7FFF : vm_reg[15:0];
                if (ws_reg)
                    w_out_reg <= (wm_reg > W'(32768)) ? 16'sh8000
                                 : 16'(17'd0 - wm_reg[16:0]);
                else
                    w_out_reg <= (wm_reg > W'(32767)) ? 16'sh7FFF : wm_reg[15:0];
                phase_out_reg   <= phase;
                boosted_out_reg <= boost_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.unit_done = u_done;
    assign stat.cond_v    = (lim_v != 15'd0) && (vm_reg > W'(lim_v));
    assign stat.cond_w    = (lim_w != 15'd0) && (wm_reg > W'(lim_w));
    assign stat.phase_nz  = (phase != 2'd0);
    assign stat.mode_nz   = (cfg.limit_mode != 2'd0);
    assign stat.recovery  = recovery_reg;
    assign stat.boost_ok  = (mw_reg != '0)
                            && (mw_reg < (W'(cfg.min_wheel_speed) << VEL_FRAC_BITS));

    assign v_out         = v_out_reg;
    assign w_out         = w_out_reg;
    assign startup_phase = phase_out_reg;
    assign boosted       = boosted_out_reg;

endmodule

// ===== rtl/dvl_controller.sv =====
// ----------------------------------------------------------------------------
// dvl_controller
// Sequencer of the velocity limiter: accepts requests, steps the datapath
// through the startup, mode and boost passes and hands off the result.
// ----------------------------------------------------------------------------
module dvl_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         req_type,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dvl_pkg::dp_stat_t  stat,
    output dvl_pkg::dp_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LSI  = 5'd1;
    localparam logic [4:0] S_LS0  = 5'd2;
    localparam logic [4:0] S_LS1  = 5'd3;
    localparam logic [4:0] S_LS2  = 5'd4;
    localparam logic [4:0] S_LS3  = 5'd5;
    localparam logic [4:0] S_MD0  = 5'd6;
    localparam logic [4:0] S_MD1  = 5'd7;
    localparam logic [4:0] S_BW   = 5'd8;
    localparam logic [4:0] S_BT   = 5'd9;
    localparam logic [4:0] S_BD   = 5'd10;
    localparam logic [4:0] S_BC   = 5'd11;
    localparam logic [4:0] S_BM0  = 5'd12;
    localparam logic [4:0] S_BM1  = 5'd13;
    localparam logic [4:0] S_BK   = 5'd14;
    localparam logic [4:0] S_BR   = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic [4:0] after_mode, after_start;

    assign accept      = in_valid && (state_reg == S_IDLE);
    assign after_mode  = stat.recovery ? S_BW : S_FIN;
    assign after_start = stat.mode_nz ? S_MD0 : after_mode;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = dvl_pkg::OP_NONE;
        cmd.lim        = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority case (req_type)
                        dvl_pkg::REQ_CMD:
                        begin
                            cmd.op = dvl_pkg::OP_LOAD;
                            if (stat.phase_nz)
                            begin
                                ret_next   = dvl_pkg::LIM_START;
                                state_next = S_LSI;
                            end
                            else
                                state_next = after_start;
                        end
                        dvl_pkg::REQ_STATUS: cmd.op = dvl_pkg::OP_STATUS;
                        dvl_pkg::REQ_TICK:   cmd.op = dvl_pkg::OP_TICK;
                        default:             cmd.op = dvl_pkg::OP_NONE;
                    endcase
                end
            end
            S_LSI:
            begin
                cmd.op     = dvl_pkg::OP_SET1;
                state_next = S_LS0;
            end
            S_LS0:
            begin
                if (stat.cond_v)
                begin
                    cmd.op = dvl_pkg::OP_DIV_V;
                    if (stat.unit_done)
                        state_next = S_LS1;
                end
                else
                    state_next = S_LS1;
            end
            S_LS1:
            begin
                if (stat.cond_w)
                begin
                    cmd.op = dvl_pkg::OP_DIV_W;
                    if (stat.unit_done)
                        state_next = S_LS2;
                end
                else
                    state_next = S_LS2;
            end
            S_LS2:
            begin
                cmd.op = dvl_pkg::OP_MUL_VSC;
                if (stat.unit_done)
                    state_next = S_LS3;
            end
            S_LS3:
            begin
                cmd.op = dvl_pkg::OP_MUL_WSC;
                if (stat.unit_done)
                begin
                    unique case (ret_reg)
                        dvl_pkg::LIM_START: state_next = after_start;
                        dvl_pkg::LIM_MODE:  state_next = after_mode;
                        default:            state_next = S_BK;
                    endcase
                end
            end
            S_MD0:
            begin
                cmd.op = dvl_pkg::OP_MUL_VSS;
                if (stat.unit_done)
                    state_next = S_MD1;
            end
            S_MD1:
            begin
                cmd.op = dvl_pkg::OP_MUL_WSS;
                if (stat.unit_done)
                begin
                    ret_next   = dvl_pkg::LIM_MODE;
                    state_next = S_LSI;
                end
            end
            S_BW:
            begin
                cmd.op     = dvl_pkg::OP_WHEEL;
                state_next = S_BT;
            end
            S_BT:
                state_next = stat.boost_ok ? S_BD : S_FIN;
            S_BD:
            begin
                cmd.op = dvl_pkg::OP_DIV_SB;
                if (stat.unit_done)
                    state_next = S_BC;
            end
            S_BC:
            begin
                cmd.op     = dvl_pkg::OP_COPY;
                state_next = S_BM0;
            end
            S_BM0:
            begin
                cmd.op = dvl_pkg::OP_MUL_VSB;
                if (stat.unit_done)
                    state_next = S_BM1;
            end
            S_BM1:
            begin
                cmd.op = dvl_pkg::OP_MUL_WSB;
                if (stat.unit_done)
                begin
                    ret_next   = dvl_pkg::LIM_BOOST;
                    state_next = S_LSI;
                end
            end
            S_BK:
            begin
                cmd.op = dvl_pkg::OP_MUL_KP;
                if (stat.unit_done)
                    state_next = S_BR;
            end
            S_BR:
            begin
                cmd.op     = dvl_pkg::OP_DECIDE;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = dvl_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= dvl_pkg::LIM_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/dvl_checker.sv =====
// ----------------------------------------------------------------------------
// dvl_checker
// Port-level checks of the velocity limiter, bound to the top level.
// ----------------------------------------------------------------------------
module dvl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A held result keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An accepted command makes the block busy in the following cycle.
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == dvl_pkg::REQ_CMD |=> !s_tready)
        else $error("command accepted without going busy");

    // Status events and ticks never produce a new result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != dvl_pkg::REQ_CMD |=> !$rose(m_tvalid))
        else $error("result after a non-command request");

    // The startup phase field never shows the unused code.
    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:32] != 2'd3)
        else $error("invalid startup phase");

endmodule

bind diff_drive_velocity_limiter_unit dvl_checker u_dvl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the differential-drive velocity limiter. A queue of
// requests (commands, status events, ticks) is streamed in bursts; a local
// model of the limiter predicts each result, which the monitor compares field
// by field. Configuration is rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] v;
        logic [15:0] w;
        logic [2:0]  code;
    } request_t;

    typedef struct packed {
        logic [15:0] v;
        logic [15:0] w;
        logic [1:0]  phase;
        logic        boosted;
    } motion_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    diff_drive_velocity_limiter_unit dut (.*);

    always #2 clk = ~clk;

    // Local copy of the configuration and the limiter state.
    logic [1:0]  m_mode;
    logic [16:0] m_scale;
    logic [14:0] m_lin, m_ang, m_p2, m_sang, m_minw, m_half;
    logic        m_drv, m_last, m_rec;
    logic [11:0] m_ticks;

    request_t pending_requests[$];
    motion_t  expected_motion[$];
    int       errors = 0;
    int       commands_sent = 0, results_seen = 0, boosts_seen = 0;
    bit       stimulus_done = 1'b0;

    function automatic longint unsigned mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint apply_scale(longint x, longint unsigned s);
        longint unsigned r;
        r = (mag(x) * s) >> 16;
        return x < 0 ? -longint'(r) : longint'(r);
    endfunction

    // Common factor that brings both axes inside their limits.
    function automatic longint unsigned common_factor(longint v, longint w,
                                                      longint unsigned lv,
                                                      longint unsigned lw);
        longint unsigned s, q;
        s = 65536;
        if (lv > 0 && mag(v) > lv)
        begin
            q = (lv << 16) / mag(v);
            if (q < s) s = q;
        end
        if (lw > 0 && mag(w) > lw)
        begin
            q = (lw << 16) / mag(w);
            if (q < s) s = q;
        end
        return s;
    endfunction

    function automatic logic [15:0] saturate(longint x);
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        return x[15:0];
    endfunction

    task automatic write_setting(logic [2:0] idx, logic [31:0] val);
        case (idx)
            dvl_pkg::REG_LIMIT_MODE:    m_mode = val[1:0];
            dvl_pkg::REG_SPEED_SCALE:
                m_scale = (val[16:0] > dvl_pkg::ONE_Q16) ? dvl_pkg::ONE_Q16 : val[16:0];
            dvl_pkg::REG_LIMIT_LINEAR:  m_lin = val[14:0];
            dvl_pkg::REG_LIMIT_ANGULAR: m_ang = val[14:0];
            dvl_pkg::REG_PHASE2_LIMIT:  m_p2 = val[14:0];
            dvl_pkg::REG_STARTUP_ANG:   m_sang = val[14:0];
            dvl_pkg::REG_MIN_WHEEL:     m_minw = val[14:0];
            default:                    m_half = val[14:0];
        endcase
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Predicts the result of one accepted request and updates the state.
    task automatic predict_limiter(request_t r);
        longint v, w, vv, p, nv, nw;
        longint unsigned s, lin, a, b, mw, sb, clip;
        motion_t res;
        res.phase = 2'd0;
        res.boosted = 1'b0;
        if (r.kind == dvl_pkg::REQ_STATUS)
        begin
            if (r.code == dvl_pkg::ST_DRIVING)
            begin
                if (!m_last)
                begin
                    m_drv = 1'b1;
                    m_ticks = '0;
                end
            end
            else
            begin
                m_drv = 1'b0;
                m_ticks = '0;
            end
            m_last = (r.code == dvl_pkg::ST_DRIVING);
            m_rec = (r.code == dvl_pkg::ST_RECOVERY);
            return;
        end
        if (r.kind == dvl_pkg::REQ_TICK)
        begin
            if (m_drv && m_ticks != 12'hFFF) m_ticks++;
            return;
        end
        if (r.kind != dvl_pkg::REQ_CMD) return;
        v = longint'($signed(r.v));
        w = longint'($signed(r.w));
        if (m_drv)
        begin
            lin = 0;
            if (m_ticks < dvl_pkg::PHASE1_END_TICKS_DEF)
            begin
                lin = dvl_pkg::PHASE1_LINEAR_LIMIT_DEF;
                res.phase = 2'd1;
            end
            else if (m_ticks < dvl_pkg::PHASE2_END_TICKS_DEF)
            begin
                lin = m_p2;
                res.phase = (lin > 0) ? 2'd2 : 2'd0;
            end
            if (lin > 0)
            begin
                s = common_factor(v, w, lin, m_sang);
                v = apply_scale(v, s);
                w = apply_scale(w, s);
            end
        end
        if (m_mode != 0)
        begin
            v = apply_scale(v, m_scale);
            w = apply_scale(w, m_scale);
            s = common_factor(v, w, m_lin, m_ang);
            v = apply_scale(v, s);
            w = apply_scale(w, s);
        end
        if (m_rec)
        begin
            vv = v * (64'sd1 << dvl_pkg::VEL_FRAC_BITS_DEF);
            p = w * longint'(m_half);
            a = mag(vv - p);
            b = mag(vv + p);
            mw = a > b ? a : b;
            if (mw > 0 && mw < (longint'(m_minw) << dvl_pkg::VEL_FRAC_BITS_DEF))
            begin
                sb = (longint'(m_minw) << (2 * dvl_pkg::VEL_FRAC_BITS_DEF + 16)) / mw;
                nv = apply_scale(v, sb);
                nw = apply_scale(w, sb);
                clip = common_factor(nv, nw, dvl_pkg::BOOST_MAX_LINEAR_DEF,
                                     dvl_pkg::BOOST_MAX_ANGULAR_DEF);
                if (((sb * clip) >> 16) > 65536)
                begin
                    v = apply_scale(nv, clip);
                    w = apply_scale(nw, clip);
                    res.boosted = 1'b1;
                end
            end
        end
        res.v = saturate(v);
        res.w = saturate(w);
        expected_motion.push_back(res);
    endtask

    function automatic request_t make_request(logic [1:0] kind, logic [15:0] v,
                                              logic [15:0] w, logic [2:0] code);
        request_t r;
        r.kind = kind; r.v = v; r.w = w; r.code = code;
        return r;
    endfunction

    // Random command, mostly small so boosts and limits both get exercised.
    function automatic request_t random_command();
        logic [15:0] v, w;
        case ($urandom_range(0, 3))
            0:
            begin
                v = 16'($urandom);
                w = 16'($urandom);
            end
            1:
            begin
                v = 16'($urandom_range(0, 120) - 60);
                w = 16'($urandom_range(0, 120) - 60);
            end
            2:
            begin
                v = 16'($urandom_range(0, 6000) - 3000);
                w = 16'($urandom_range(0, 8000) - 4000);
            end
            default:
            begin
                v = 16'($urandom_range(0, 16) - 8);
                w = 16'($urandom_range(0, 400) - 200);
            end
        endcase
        return make_request(dvl_pkg::REQ_CMD, v, w, 3'($urandom));
    endfunction

    // Marks that the request on the bus was taken at the last rising edge.
    bit in_taken = 1'b0;
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
    end

    // Driver: streams the pending queue in bursts separated by random gaps.
    int burst_left = 0, gap_left = 0;
    bit hold_sender = 1'b0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_taken)
            begin
                // request still waiting for acceptance
            end
            else if (pending_requests.size() > 0 && !hold_sender && gap_left == 0)
            begin
                request_t r;
                r = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= r.kind;
                s_tdata <= {5'b0, r.code, r.w, r.v};
                predict_limiter(r);
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // Receiver stall pattern: alternating ready and stall stretches.
    int stall_count = 0;
    always @(negedge clk)
    begin
        if (stall_count > 0)
        begin
            stall_count--;
        end
        else
        begin
            m_tready <= ~m_tready;
            stall_count = m_tready ? $urandom_range(0, 5) : $urandom_range(0, 25);
        end
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            motion_t got, exp_res;
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[33:32], m_tdata[34]};
            results_seen++;
            if (got.boosted) boosts_seen++;
            if (expected_motion.size() == 0)
            begin
                $error("unexpected result v_out=%0d", $signed(got.v));
                errors++;
            end
            else
            begin
                exp_res = expected_motion.pop_front();
                if (got.v !== exp_res.v)
                begin
                    $error("v_out expected %0d actual %0d", $signed(exp_res.v), $signed(got.v));
                    errors++;
                end
                if (got.w !== exp_res.w)
                begin
                    $error("w_out expected %0d actual %0d", $signed(exp_res.w), $signed(got.w));
                    errors++;
                end
                if (got.phase !== exp_res.phase)
                begin
                    $error("startup_phase expected %0d actual %0d", exp_res.phase, got.phase);
                    errors++;
                end
                if (got.boosted !== exp_res.boosted)
                begin
                    $error("boosted expected %0d actual %0d", exp_res.boosted, got.boosted);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_tvalid || expected_motion.size() > 0)
            @(negedge clk);
        // A status event or tick may still be in flight behind the last result.
        repeat (400) @(negedge clk);
    endtask

    // A driving run with recovery and short tick runs, mixed with commands.
    task automatic queue_scenario(int cmds);
        int n;
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'($urandom),
                                                16'($urandom),
                                                ($urandom_range(0, 2) == 0) ? 3'd4 : 3'd1));
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'($urandom),
                                                16'($urandom), dvl_pkg::ST_DRIVING));
        for (int i = 0; i < cmds; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(1, 10);
                    repeat (n) pending_requests.push_back(
                        make_request(dvl_pkg::REQ_TICK, 16'($urandom), 16'($urandom),
                                     3'($urandom)));
                end
                1:
                    pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS,
                                                            16'($urandom), 16'($urandom),
                                                            3'($urandom_range(0, 7))));
                2:
                    pending_requests.push_back(make_request(2'd3, 16'($urandom),
                                                            16'($urandom), 3'($urandom)));
                default:
                begin
                    pending_requests.push_back(random_command());
                    commands_sent++;
                end
            endcase
        end
    endtask

    task automatic random_settings(bit extreme);
        write_setting(dvl_pkg::REG_LIMIT_MODE, $urandom_range(0, 3));
        write_setting(dvl_pkg::REG_SPEED_SCALE,
                      extreme ? ($urandom_range(0, 1) ? 32'h1FFFF : 32'd0)
                              : $urandom_range(20000, 70000));
        write_setting(dvl_pkg::REG_LIMIT_LINEAR, extreme ? 32'h7FFF : $urandom_range(0, 3000));
        write_setting(dvl_pkg::REG_LIMIT_ANGULAR, extreme ? 32'd0 : $urandom_range(0, 5000));
        write_setting(dvl_pkg::REG_PHASE2_LIMIT,
                      ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 4000));
        write_setting(dvl_pkg::REG_STARTUP_ANG, extreme ? 32'h7FFF : $urandom_range(0, 4000));
        write_setting(dvl_pkg::REG_MIN_WHEEL, extreme ? 32'h7FFF : $urandom_range(0, 200));
        write_setting(dvl_pkg::REG_HALF_TRACK, extreme ? 32'h7FFF : $urandom_range(0, 2000));
    endtask

    initial
    begin
        m_mode = '0; m_scale = dvl_pkg::ONE_Q16; m_lin = '0; m_ang = '0;
        m_p2 = 15'd1229; m_sang = 15'd2048; m_minw = 15'd82; m_half = 15'd1077;
        m_drv = 1'b0; m_last = 1'b0; m_rec = 1'b0; m_ticks = '0;
        hold_sender = 1'b1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every request kind, the status edge cases
        // and the recovery boost under reset settings.
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'h7FFF, 16'h8000, 3'd7));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'h8000, 16'h7FFF, 3'd0));
        pending_requests.push_back(make_request(2'd3, 16'hFFFF, 16'hFFFF, 3'd7));
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'd0, 16'd0,
                                                dvl_pkg::ST_DRIVING));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'd4096, 16'd8192, 3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'd0, 16'd0,
                                                dvl_pkg::ST_DRIVING));
        repeat (20) pending_requests.push_back(make_request(dvl_pkg::REQ_TICK, 16'd0, 16'd0,
                                                            3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'hF000, 16'd100, 3'd0));
        repeat (30) pending_requests.push_back(make_request(dvl_pkg::REQ_TICK, 16'd0, 16'd0,
                                                            3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'd20000, 16'hC000, 3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'd0, 16'd0,
                                                dvl_pkg::ST_RECOVERY));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'd10, 16'd0, 3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'd0, 16'hFFF0, 3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'd0, 16'd0, 3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'd2, 16'd1, 3'd0));
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'd0, 16'd0, 3'd7));
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'd0, 16'd0, 3'd2));
        pending_requests.push_back(make_request(dvl_pkg::REQ_STATUS, 16'd0, 16'd0, 3'd3));
        pending_requests.push_back(make_request(dvl_pkg::REQ_CMD, 16'd10, 16'd5, 3'd0));
        commands_sent += 10;
        hold_sender = 1'b0;
        wait_drained();

        // Phases of random traffic under changing settings, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            hold_sender = 1'b1;
            random_settings(ph == 1 || ph == 5);
            hold_sender = 1'b0;
            queue_scenario(60);
            wait_drained();
        end

        $display("Covered %0d commands with %0d results checked, %0d of them boosted.",
                 commands_sent, results_seen, boosts_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/dvl_pkg.sv
rtl/dvl_datapath.sv
rtl/dvl_controller.sv
rtl/diff_drive_velocity_limiter_unit.sv
rtl/dvl_checker.sv
tb/tb.sv
